>>> sv/kebs_pkg.sv
// Shared types and constants for the Kepler equation bisection solver.
package kebs_pkg;

    localparam int CORDIC_ITERS = 30;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic signed [35:0] CORDIC_GAIN_INV = 36'sd652032874;
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

    typedef logic [4:0] iter_t;

    function automatic logic signed [35:0] atan_entry(input iter_t i);
        logic signed [35:0] r;
        r = '0;
        unique case (i)
            5'd0: r = 36'sd843314857;
            5'd1: r = 36'sd497837829;
            5'd2: r = 36'sd263043837;
            5'd3: r = 36'sd133525159;
            5'd4: r = 36'sd67021687;
            5'd5: r = 36'sd33543516;
            5'd6: r = 36'sd16775851;
            5'd7: r = 36'sd8388437;
            5'd8: r = 36'sd4194283;
            5'd9: r = 36'sd2097149;
            default: r = 36'sd1 <<< (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage

>>> sv/kebs_cordic.sv
// Iterative CORDIC sine unit, one rotation per cycle, Q1.30 output.
module kebs_cordic
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [35:0]  angle,
    output logic                done,
    output logic signed [35:0]  sine
);
    import kebs_pkg::*;

    logic signed [35:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    iter_t              i_reg, i_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [35:0] xs, ys, at;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = atan_entry(i_reg);
        if (start)
        begin
            x_next = CORDIC_GAIN_INV;
            y_next = '0;
            z_next = angle;
            i_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[35])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == iter_t'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = done_reg;
    assign sine = (y_reg > ONE_Q30) ? ONE_Q30 : ((y_reg < -ONE_Q30) ? -ONE_Q30 : y_reg);

endmodule

>>> sv/kepler_equation_bisection_solver_core.sv
// Top level of the Kepler equation bisection solver.
//  channel | valid      | stall      | payload
//  input   | in_valid   | in_stall   | mean_anomaly, eccentricity
//  output  | out_valid  | out_stall  | eccentric_anomaly, bracket_invalid
// Each valid item runs BISECTION_STEPS bisection steps, each a serial CORDIC sine evaluation
// followed by the bit-serial e*sin multiply.
// An invalid bracket has its result valid in the cycle after the transfer.
// Reset clears all control state.
// The result register holds while out_stall is high; a new item is taken once it is free.
module kepler_equation_bisection_solver_core #(
    parameter int BISECTION_STEPS = 33,
    parameter int ANGLE_FRAC_BITS = 29
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] mean_anomaly,
    input  logic [31:0] eccentricity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] eccentric_anomaly,
    output logic        bracket_invalid
);
    import kebs_pkg::*;

    localparam int AW = ANGLE_FRAC_BITS + 4;
    localparam int SH = 62 - ANGLE_FRAC_BITS;
    localparam int CW = $clog2(BISECTION_STEPS + 1);
    localparam int DW = ((AW > 32) ? AW : 32) + 2;
    localparam int ZR = (ANGLE_FRAC_BITS > 30) ? (ANGLE_FRAC_BITS - 30) : 0;
    localparam int ZL = (ANGLE_FRAC_BITS > 30) ? 0 : (30 - ANGLE_FRAC_BITS);
    localparam logic [63:0] ZRND = (64'd1 << ZR) >> 1;
    localparam logic [63:0] TP64 = (ANGLE_FRAC_BITS == 60) ? TWO_PI_Q60 :
        ((TWO_PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS));
    localparam logic [AW-1:0] TWO_PI_Q = TP64[AW-1:0];

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MID  = 5'b00010,
        S_SIN  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DEC  = 5'b10000
    } state_t;

    state_t              st_reg, st_next;
    logic [AW-1:0]       a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0]         m_reg, m_next, e_reg, e_next;
    logic [CW-1:0]       step_reg, step_next;
    logic [5:0]          bit_reg, bit_next;
    logic [63:0]         acc_reg, acc_next;
    logic [31:0]         mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                ov_reg, ov_next;
    logic [31:0]         res_reg, res_next;
    logic                inv_reg, inv_next;

    logic                cs_start, cs_done;
    logic signed [35:0]  z_in, z_red, sine_out;
    logic [63:0]         es64;
    logic signed [DW-1:0] d;
    logic [AW-1:0]       es;

    always_comb
    begin
        z_in = 36'(((64'(c_reg) + ZRND) >> ZR) << ZL);
        if (z_in > PI_Q30 + HALF_PI_Q30)
            z_red = z_in - TWO_PI_Q30;
        else if (z_in > HALF_PI_Q30)
            z_red = PI_Q30 - z_in;
        else
            z_red = z_in;
    end

    kebs_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cs_start),
        .angle (z_red),
        .done  (cs_done),
        .sine  (sine_out)
    );

    assign es64 = (acc_reg + (64'd1 << (SH - 1))) >> SH;
    assign es = es64[AW-1:0];
    assign d = neg_reg ? ($signed(DW'(c_reg)) - $signed(DW'(m_reg)) + $signed(DW'(es)))
                       : ($signed(DW'(c_reg)) - $signed(DW'(m_reg)) - $signed(DW'(es)));

    assign cs_start = (st_reg == S_MID);

    always_comb
    begin
        st_next = st_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        m_next = m_reg;
        e_next = e_reg;
        step_next = step_reg;
        bit_next = bit_reg;
        acc_next = acc_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        ov_next = ov_reg;
        res_next = res_reg;
        inv_next = inv_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    m_next = mean_anomaly;
                    e_next = eccentricity;
                    if (mean_anomaly == 32'd0 || 64'(mean_anomaly) >= TP64)
                    begin
                        res_next = '0;
                        inv_next = 1'b1;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        a_next = '0;
                        b_next = TWO_PI_Q;
                        step_next = '0;
                        st_next = S_MID;
                        c_next = TWO_PI_Q >> 1;
                    end
                end
            end
            S_MID:
                st_next = S_SIN;
            S_SIN:
            begin
                if (cs_done)
                begin
                    neg_next = sine_out[35];
                    mag_next = 32'(sine_out[35] ? -sine_out : sine_out);
                    acc_next = '0;
                    bit_next = '0;
                    st_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (e_reg[bit_reg[4:0]])
                    acc_next = acc_reg + ({32'd0, mag_reg} << bit_reg[4:0]);
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd31)
                    st_next = S_DEC;
            end
            S_DEC:
            begin
                if (d > 0)
                    b_next = c_reg;
                else if (d < 0)
                    a_next = c_reg;
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(BISECTION_STEPS - 1))
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        res_next = 32'(c_reg);
                        inv_next = 1'b0;
                        ov_next = 1'b1;
                        st_next = S_IDLE;
                    end
                    else
                        step_next = step_reg;
                end
                else
                begin
                    c_next = ((d > 0) ? a_reg : c_reg) +
                             ((((d > 0) ? c_reg : b_reg) - ((d > 0) ? a_reg : c_reg)) >> 1);
                    if (d == 0)
                        c_next = a_reg + ((b_reg - a_reg) >> 1);
                    st_next = S_MID;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            step_reg <= '0;
            bit_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            step_reg <= step_next;
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        m_reg <= m_next;
        e_reg <= e_next;
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        inv_reg <= inv_next;
    end

    assign in_stall = (st_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign eccentric_anomaly = res_reg;
    assign bracket_invalid = inv_reg;

endmodule
